// ===== hw/rtl/srvm_pkg.sv =====
// Shared types and constants for the shifted raster-op video memory.
// Used by the front end, the command queue and the execution back end.
package srvm_pkg;

    localparam int ADDR_W      = 13;
    localparam int MEM_DEPTH   = 8192;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Offset between the two bytes that one shifted access touches.
    localparam logic [ADDR_W-1:0] ROW_STEP  = 13'h0100;
    // Colour memory index mask used for accesses in the top 32 bytes of a row.
    localparam logic [ADDR_W-1:0] CIDX_MASK = 13'h1eff;

    localparam logic [2:0] KIND_VWR   = 3'd0;
    localparam logic [2:0] KIND_VRD   = 3'd1;
    localparam logic [2:0] KIND_CWR   = 3'd2;
    localparam logic [2:0] KIND_CRD   = 3'd3;
    localparam logic [2:0] KIND_SHIFT = 3'd4;
    localparam logic [2:0] KIND_MODE  = 3'd5;

    // One classified bus access as it travels from the front end to the back end.
    typedef struct packed {
        logic [2:0]        kind;
        logic              nib_low;
        logic              top_zero;
        logic              right_edge;
        logic [ADDR_W-1:0] a0;
        logic [ADDR_W-1:0] a1;
        logic [ADDR_W-1:0] cidx;
        logic [5:0]        pal_idx;
        logic              red_hi;
        logic [7:0]        data;
    } cmd_t;

endpackage

// ===== hw/rtl/shifted_rop_video_memory.sv =====
// Top level of the shifted raster-op video memory with its colour memory.
// Instantiates srvm_front, srvm_queue and srvm_back; depends on srvm_pkg.
//
// Each bus access is one input beat and gives exactly one result beat. After
// reset the block clears both 8192-byte memories, one address per cycle, and
// takes no beat until the clear ends. Then a video read or write runs through
// the idle, execute and final states of the back end, as the video memory has
// a single read port (first byte read, second byte read with first byte write,
// second byte write); colour and control accesses end in the execute state. A
// two-entry queue lets new beats be taken while the back end works, and an
// output register holds a finished result until it is taken.
module shifted_rop_video_memory
    import srvm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [13:0] address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        palette_valid,
    output logic [5:0]  palette_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_ready, q_push, q_pop, q_nonempty, clearing;

    srvm_front u_front (
        .kind       (kind),
        .address    (address),
        .write_data (write_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .clearing   (clearing),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    srvm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .head     (head_cmd),
        .nonempty (q_nonempty)
    );

    srvm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (head_cmd),
        .q_nonempty    (q_nonempty),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .palette_valid (palette_valid),
        .palette_index (palette_index),
        .red           (red),
        .green         (green),
        .blue          (blue)
    );

endmodule

// ===== hw/rtl/srvm_front.sv =====
// Front end: accepts bus accesses and classifies them into commands.
// Depends on srvm_pkg for the command type and kind codes.
module srvm_front
    import srvm_pkg::*;
(
    input  logic [2:0]  kind,
    input  logic [13:0] address,
    input  logic [7:0]  write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        clearing,
    input  logic        q_ready,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic top_zero;
    logic [ADDR_W-1:0] a0;

    assign top_zero = (address[7:5] == 3'b000);
    assign a0       = address[ADDR_W-1:0];

    // Nothing is taken while the memories are being cleared after reset.
    assign in_ready = q_ready && !clearing;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_cmd            = '0;
        q_cmd.kind       = kind;
        q_cmd.nib_low    = address[13];
        q_cmd.top_zero   = top_zero;
        q_cmd.right_edge = (address[12:8] == 5'h1f);
        q_cmd.a0         = a0;
        q_cmd.a1         = a0 + ROW_STEP;
        q_cmd.cidx       = top_zero ? (a0 & CIDX_MASK) : a0;
        q_cmd.pal_idx    = {address[9], address[4:0]};
        q_cmd.red_hi     = address[8];
        q_cmd.data       = write_data;
    end

endmodule

// ===== hw/rtl/srvm_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on srvm_pkg for the command type and the queue depth.
module srvm_queue
    import srvm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic ready,
    input  logic pop,
    output cmd_t head,
    output logic nonempty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign ready    = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/srvm_back.sv =====
// Back end: control registers, video and colour memories, shifter, raster ops.
// Runs each command as a short sequence; depends on srvm_pkg.
module srvm_back
    import srvm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       q_head,
    input  logic       q_nonempty,
    output logic       q_pop,
    output logic       clearing,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       palette_valid,
    output logic [5:0] palette_index,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [3:0] ROP_REPLACE  = 4'd0;
    localparam logic [3:0] ROP_OR_SRC   = 4'd1;
    localparam logic [3:0] ROP_XM_OR    = 4'd2;
    localparam logic [3:0] ROP_SET      = 4'd3;
    localparam logic [3:0] ROP_AND_SRC  = 4'd4;
    localparam logic [3:0] ROP_KEEP     = 4'd5;
    localparam logic [3:0] ROP_XNOR_SRC = 4'd6;
    localparam logic [3:0] ROP_OR_NSRC  = 4'd7;
    localparam logic [3:0] ROP_NDST_SRC = 4'd8;
    localparam logic [3:0] ROP_XOR_SRC  = 4'd9;
    localparam logic [3:0] ROP_INVERT   = 4'd10;
    localparam logic [3:0] ROP_NAND     = 4'd11;
    localparam logic [3:0] ROP_CLEAR    = 4'd12;
    localparam logic [3:0] ROP_CLR_SRC  = 4'd13;
    localparam logic [3:0] ROP_NOR      = 4'd14;

    function automatic logic [7:0] rop(input logic [3:0] op, input logic [7:0] v,
                                       input logic [7:0] d, input logic [7:0] m);
        logic [7:0] r;
        case (op)
            ROP_REPLACE:  r = (v & ~m) | (d & m);
            ROP_OR_SRC:   r = v | (d & m);
            ROP_XM_OR:    r = (v ^ m) | (d & m);
            ROP_SET:      r = v | m;
            ROP_AND_SRC:  r = v & (d | ~m);
            ROP_KEEP:     r = v;
            ROP_XNOR_SRC: r = v ^ (d & m) ^ m;
            ROP_OR_NSRC:  r = v | (~d & m);
            ROP_NDST_SRC: r = (v & ~m) | (~v & d & m);
            ROP_XOR_SRC:  r = v ^ (d & m);
            ROP_INVERT:   r = v ^ m;
            ROP_NAND:     r = (v & ~m) | (~(v & d) & m);
            ROP_CLEAR:    r = v & ~m;
            ROP_CLR_SRC:  r = v & ~(d & m);
            ROP_NOR:      r = (v & ~m) | (~(v | d) & m);
            default:      r = (v & ~m) | (~d & m);
        endcase
        return r;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

    logic [7:0] vmem [MEM_DEPTH];
    logic [7:0] cmem [MEM_DEPTH];

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg;
    logic [7:0]        shift_reg;
    logic [7:0]        mode_reg;
    logic [4:0]        latch_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [7:0]        vm_q_reg;
    logic [7:0]        cm_q_reg;
    logic [7:0]        g0_reg;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;
    logic              pal_valid_reg;
    logic [5:0]        pal_idx_reg;
    logic [7:0]        red_reg, green_reg, blue_reg;

    logic [3:0]  nib;
    logic [3:0]  sh;
    logic [15:0] m1_full, m1;
    logic [7:0]  m0;
    logic [7:0]  dsrc;
    logic [15:0] d1;
    logic        is_video, is_vwr, vw_ok, stamp_ok, fire, out_load, pal_on;
    logic [7:0]  g;
    logic [15:0] g_rot;

    logic              vm_re, vm_we, cm_re, cm_we;
    logic [ADDR_W-1:0] vm_raddr, vm_waddr, cm_waddr;
    logic [7:0]        vm_wdata, cm_wdata;

    // Shifter and masks for the command in flight.
    assign nib     = cmd_reg.nib_low ? shift_reg[3:0] : shift_reg[7:4];
    assign sh      = 4'd8 - {1'b0, nib[3:1]};
    assign m1_full = 16'h00ff << sh;
    // At the right edge the roll bit picks which of the two bytes is dropped.
    assign m1      = (cmd_reg.right_edge && !mode_reg[4]) ? 16'h0000 : m1_full;
    assign m0      = (cmd_reg.right_edge && mode_reg[4]) ? 8'h00 : m1_full[15:8];
    assign dsrc    = nib[0] ? reverse8(cmd_reg.data) : cmd_reg.data;
    assign d1      = {8'h00, dsrc} << sh;

    assign is_video = (cmd_reg.kind == KIND_VWR) || (cmd_reg.kind == KIND_VRD);
    assign is_vwr   = (cmd_reg.kind == KIND_VWR);
    assign vw_ok    = !cmd_reg.top_zero || mode_reg[5];
    assign stamp_ok = !cmd_reg.nib_low && !mode_reg[7];
    assign fire     = !out_valid_reg || out_ready;
    assign pal_on   = (cmd_reg.kind == KIND_CWR) && cmd_reg.top_zero && mode_reg[6];

    assign q_pop    = (state_reg == ST_IDLE) && !clr_busy_reg && q_nonempty;
    assign out_load = fire && (((state_reg == ST_EXEC) && !is_video) || (state_reg == ST_FIN));
    assign clearing = clr_busy_reg;

    // A video read gathers both bytes and rotates right by the shift.
    assign g     = g0_reg | (vm_q_reg & m1[7:0]);
    assign g_rot = {g, g} >> sh[2:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_video)
                begin
                    state_next = ST_FIN;
                end
                else if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Video memory: first byte read at dispatch, second byte read while the
    // first is written back, second byte written in the final cycle.
    always_comb
    begin
        vm_re    = q_pop || ((state_reg == ST_EXEC) && is_video);
        vm_raddr = (state_reg == ST_IDLE) ? q_head.a0 : cmd_reg.a1;
        vm_we    = 1'b0;
        vm_waddr = cmd_reg.a0;
        vm_wdata = 8'h00;
        if (clr_busy_reg)
        begin
            vm_we    = 1'b1;
            vm_waddr = clr_cnt_reg;
        end
        else if ((state_reg == ST_EXEC) && is_vwr && vw_ok)
        begin
            vm_we    = 1'b1;
            vm_wdata = rop(mode_reg[3:0], vm_q_reg, d1[15:8], m0);
        end
        else if ((state_reg == ST_FIN) && is_vwr && vw_ok && fire)
        begin
            vm_we    = 1'b1;
            vm_waddr = cmd_reg.a1;
            vm_wdata = rop(mode_reg[3:0], vm_q_reg, d1[7:0], m1[7:0]);
        end
    end

    always_comb
    begin
        cm_re    = q_pop;
        cm_we    = 1'b0;
        cm_waddr = cmd_reg.cidx;
        cm_wdata = 8'h00;
        if (clr_busy_reg)
        begin
            cm_we    = 1'b1;
            cm_waddr = clr_cnt_reg;
        end
        else if ((state_reg == ST_EXEC) && is_vwr && vw_ok && stamp_ok && (m0 != 8'h00))
        begin
            cm_we    = 1'b1;
            cm_waddr = cmd_reg.a0;
            cm_wdata = {3'b000, latch_reg};
        end
        else if ((state_reg == ST_EXEC) && (cmd_reg.kind == KIND_CWR) && fire)
        begin
            if (cmd_reg.top_zero)
            begin
                cm_we    = 1'b1;
                cm_wdata = cmd_reg.data;
            end
            else if (!mode_reg[7])
            begin
                cm_we    = 1'b1;
                cm_wdata = {3'b000, cmd_reg.data[4:0]};
            end
        end
        // The second byte is stamped even for a shift of eight, where its
        // video bits stay untouched.
        else if ((state_reg == ST_FIN) && is_vwr && vw_ok && stamp_ok && fire
                 && (m1 != 16'h0000))
        begin
            cm_we    = 1'b1;
            cm_waddr = cmd_reg.a1;
            cm_wdata = {3'b000, latch_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vmem[vm_waddr] <= vm_wdata;
        end
        if (vm_re)
        begin
            vm_q_reg <= vmem[vm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cmem[cm_waddr] <= cm_wdata;
        end
        if (cm_re)
        begin
            cm_q_reg <= cmem[q_head.cidx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= '0;
            mode_reg      <= '0;
            latch_reg     <= '0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if ((state_reg == ST_EXEC) && fire)
            begin
                if (cmd_reg.kind == KIND_SHIFT)
                begin
                    shift_reg <= cmd_reg.data;
                end
                if (cmd_reg.kind == KIND_MODE)
                begin
                    mode_reg <= cmd_reg.data;
                end
                if (cmd_reg.kind == KIND_CWR)
                begin
                    latch_reg <= cmd_reg.data[4:0];
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if ((state_reg == ST_EXEC) && (cmd_reg.kind == KIND_VRD))
        begin
            g0_reg <= vm_q_reg & m0;
        end
        if (out_load)
        begin
            if (state_reg == ST_FIN)
            begin
                read_data_reg <= (cmd_reg.kind == KIND_VRD) ? g_rot[7:0] : 8'h00;
            end
            else
            begin
                read_data_reg <= (cmd_reg.kind == KIND_CRD) ? cm_q_reg : 8'h00;
            end
            pal_valid_reg <= pal_on;
            pal_idx_reg   <= pal_on ? cmd_reg.pal_idx : 6'd0;
            red_reg       <= pal_on ? {cmd_reg.data[1:0], 1'b0, cmd_reg.data[1:0], 1'b0,
                                       cmd_reg.data[1:0]} | (cmd_reg.red_hi ? 8'h24 : 8'h00)
                                    : 8'h00;
            green_reg     <= pal_on ? {cmd_reg.data[7:5], cmd_reg.data[7:5],
                                       cmd_reg.data[7:6]} : 8'h00;
            blue_reg      <= pal_on ? {cmd_reg.data[4:2], cmd_reg.data[4:2],
                                       cmd_reg.data[4:3]} : 8'h00;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign palette_valid = pal_valid_reg;
    assign palette_index = pal_idx_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !q_pop)
        else $error("command dispatched during memory clear");

    a_fin_only_video: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> ((cmd_reg.kind == KIND_VWR) || (cmd_reg.kind == KIND_VRD)))
        else $error("final video step reached by a non-video command");

    a_vmem_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (vm_we && vm_re) |-> (vm_waddr != vm_raddr))
        else $error("video memory read and write collide on one address");

    a_clear_length: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> ($past(clr_cnt_reg) == '1))
        else $error("memory clear ended early");

endmodule

// ===== sim/tb_shifted_rop_video_memory.sv =====
// Self-checking testbench for shifted_rop_video_memory: directed bus accesses, then random ones.
// Holds its own model of both memories and the control registers; depends on srvm_pkg.
module tb_shifted_rop_video_memory;
    timeunit 1ns;
    timeprecision 1ps;

    import srvm_pkg::*;

    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam logic [7:0] MODE_ROLL     = 8'h10;
    localparam logic [7:0] MODE_LOW_ROWS = 8'h20;
    localparam logic [7:0] MODE_PALETTE  = 8'h40;
    localparam logic [7:0] MODE_NO_COLOR = 8'h80;

    localparam logic [12:0] ROW_OFFSET = 13'h0100;
    localparam logic [12:0] COLOR_FOLD = 13'h1eff;

    localparam int RANDOM_ACCESSES = 1150;
    localparam int STALL_LIMIT     = 40000;
    localparam int DRAIN_CYCLES    = 16;

    typedef enum bit [3:0] {
        ROP_REPLACE     = 4'd0,
        ROP_OR          = 4'd1,
        ROP_INV_OR      = 4'd2,
        ROP_SET         = 4'd3,
        ROP_AND         = 4'd4,
        ROP_KEEP        = 4'd5,
        ROP_XNOR        = 4'd6,
        ROP_OR_INV      = 4'd7,
        ROP_INV_AND     = 4'd8,
        ROP_XOR         = 4'd9,
        ROP_INVERT      = 4'd10,
        ROP_NAND        = 4'd11,
        ROP_CLEAR       = 4'd12,
        ROP_AND_NOT     = 4'd13,
        ROP_NOR         = 4'd14,
        ROP_REPLACE_INV = 4'd15
    } rop_t;

    typedef struct packed {
        bit [7:0] read_data;
        bit       palette_valid;
        bit [5:0] palette_index;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
    } bus_reply_t;

    class video_bus_model;
        bit [7:0] video_mem [8192];
        bit [7:0] color_mem [8192];
        bit [7:0] shift_ctl;
        bit [7:0] mode_ctl;
        bit [4:0] color_latch;
        bus_reply_t pending_replies [$];
        int errors;
        int palette_updates;
        int kind_count [8];

        function bit [3:0] nibble_for(bit [13:0] a);
            return a[13] ? shift_ctl[3:0] : shift_ctl[7:4];
        endfunction

        function bit [7:0] reverse_byte(bit [7:0] v);
            bit [7:0] r;
            for (int k = 0; k < 8; k++)
                r[7-k] = v[k];
            return r;
        endfunction

        // The second mask is kept at 16 bits: the color stamp looks at all of it.
        function int shift_masks(bit [12:0] a0, bit [3:0] c,
                                 output bit [7:0] m0, output bit [15:0] m1);
            int sh;
            sh = 8 - int'(c[3:1]);
            m1 = 16'h00ff << sh;
            m0 = m1[15:8];
            if (a0[12:8] == 5'h1f)
            begin
                if (mode_ctl[4])
                    m0 = 8'h00;
                else
                    m1 = 16'h0000;
            end
            return sh;
        endfunction

        function bit [7:0] raster_op(bit [7:0] v, bit [7:0] d, bit [7:0] m);
            bit [7:0] r;
            case (rop_t'(mode_ctl[3:0]))
                ROP_REPLACE: r = (v & ~m) | (d & m);
                ROP_OR:      r = v | (d & m);
                ROP_INV_OR:  r = (v ^ m) | (d & m);
                ROP_SET:     r = v | m;
                ROP_AND:     r = v & (d | ~m);
                ROP_KEEP:    r = v;
                ROP_XNOR:    r = v ^ (d & m) ^ m;
                ROP_OR_INV:  r = v | (~d & m);
                ROP_INV_AND: r = (v & ~m) | (~v & d & m);
                ROP_XOR:     r = v ^ (d & m);
                ROP_INVERT:  r = v ^ m;
                ROP_NAND:    r = (v & ~m) | (~(v & d) & m);
                ROP_CLEAR:   r = v & ~m;
                ROP_AND_NOT: r = v & ~(d & m);
                ROP_NOR:     r = (v & ~m) | (~(v | d) & m);
                default:     r = (v & ~m) | (~d & m);
            endcase
            return r;
        endfunction

        function void video_write(bit [13:0] a, bit [7:0] data);
            bit [3:0]  c;
            bit [12:0] a0;
            bit [12:0] a1;
            bit [7:0]  d;
            bit [7:0]  m0;
            bit [15:0] m1;
            bit [15:0] d1;
            int        sh;
            // The top rows of every 256-byte block are protected unless the mode allows them.
            if (a[7:5] == 3'b000 && !mode_ctl[5])
                return;
            c = nibble_for(a);
            a0 = a[12:0];
            a1 = a0 + ROW_OFFSET;
            d = c[0] ? reverse_byte(data) : data;
            sh = shift_masks(a0, c, m0, m1);
            d1 = {8'h00, d} << sh;
            video_mem[a0] = raster_op(video_mem[a0], d1[15:8], m0);
            video_mem[a1] = raster_op(video_mem[a1], d1[7:0], m1[7:0]);
            if (!a[13] && !mode_ctl[7])
            begin
                if (m0 != 0)
                    color_mem[a0] = {3'b000, color_latch};
                if (m1 != 0)
                    color_mem[a1] = {3'b000, color_latch};
            end
        endfunction

        function bit [7:0] video_read(bit [13:0] a);
            bit [12:0] a0;
            bit [12:0] a1;
            bit [7:0]  m0;
            bit [15:0] m1;
            bit [7:0]  g;
            bit [15:0] rot;
            int        sh;
            a0 = a[12:0];
            a1 = a0 + ROW_OFFSET;
            sh = shift_masks(a0, nibble_for(a), m0, m1);
            g = (video_mem[a0] & m0) | (video_mem[a1] & m1[7:0]);
            rot = {g, g} >> sh;
            return rot[7:0];
        endfunction

        function void note_access(bit [2:0] k, bit [13:0] a, bit [7:0] data);
            bus_reply_t rep;
            int dv;
            int rv;
            rep = '0;
            dv = int'(data);
            kind_count[k]++;
            case (k)
                KIND_VWR: video_write(a, data);
                KIND_VRD: rep.read_data = video_read(a);
                KIND_CWR:
                begin
                    color_latch = data[4:0];
                    if (a[7:5] == 3'b000)
                    begin
                        color_mem[a[12:0] & COLOR_FOLD] = data;
                        if (mode_ctl[6])
                        begin
                            rv = (dv & 'h3) * 'h49;
                            if (a[8])
                                rv = rv | 'h24;
                            rep.palette_valid = 1'b1;
                            rep.palette_index = {a[9], a[4:0]};
                            rep.red = 8'(rv);
                            rep.green = 8'(((dv & 'he0) * 'h49) >> 6);
                            rep.blue = 8'(((dv & 'h1c) * 'h49) >> 3);
                            palette_updates++;
                        end
                    end
                    else if (!mode_ctl[7])
                        color_mem[a[12:0]] = {3'b000, data[4:0]};
                end
                KIND_CRD:
                    rep.read_data = (a[7:5] == 3'b000) ? color_mem[a[12:0] & COLOR_FOLD]
                                                       : color_mem[a[12:0]];
                KIND_SHIFT: shift_ctl = data;
                KIND_MODE:  mode_ctl = data;
                default: ;
            endcase
            pending_replies.push_back(rep);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_reply(bus_reply_t got);
            bus_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: result beat with nothing outstanding, actual 0x%0h", $time, got);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("read_data", int'(want.read_data), int'(got.read_data));
            compare_field("palette_valid", int'(want.palette_valid), int'(got.palette_valid));
            compare_field("palette_index", int'(want.palette_index), int'(got.palette_index));
            compare_field("red", int'(want.red), int'(got.red));
            compare_field("green", int'(want.green), int'(got.green));
            compare_field("blue", int'(want.blue), int'(got.blue));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  kind = 3'd0;
    logic [13:0] address = 14'd0;
    logic [7:0]  write_data = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic        palette_valid;
    logic [5:0]  palette_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    video_bus_model model = new;
    int burst_left = 0;

    shifted_rop_video_memory dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .address       (address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .palette_valid (palette_valid),
        .palette_index (palette_index),
        .red           (red),
        .green         (green),
        .blue          (blue)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Bursts of back-to-back beats separated by short gaps, with an occasional long burst.
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
        return $urandom_range(1, 6);
    endfunction

    // Mostly a few rows near the bottom and top of memory so that accesses overlap.
    function automatic bit [13:0] pick_address();
        bit [4:0] row;
        bit [2:0] col_hi;
        bit [4:0] col_lo;
        case ($urandom_range(0, 3))
            0: row = 5'h1f;
            1: row = 5'h00;
            2: row = 5'($urandom_range(0, 3));
            default: row = 5'($urandom_range(0, 31));
        endcase
        col_hi = ($urandom_range(0, 3) == 0) ? 3'b000 : 3'($urandom_range(0, 7));
        col_lo = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
        if ($urandom_range(0, 6) == 0)
            return 14'($urandom_range(0, 16383));
        return {1'($urandom_range(0, 1)), row, col_hi, col_lo};
    endfunction

    // Called at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_access(input bit [2:0] k, input bit [13:0] a, input bit [7:0] d,
                               input int gap);
        in_valid <= 1'b1;
        kind <= k;
        address <= a;
        write_data <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        int style;
        int style_left;
        int cyc;
        style = 0;
        style_left = 0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            if (style_left == 0)
            begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            cyc++;
            case (style)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 9) < 6);
                2: out_ready <= (cyc % 7) > 1;
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        bus_reply_t seen;
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            idle_cycles++;
            if (in_valid && in_ready)
            begin
                model.note_access(kind, address, write_data);
                idle_cycles = 0;
            end
            if (out_valid && out_ready)
            begin
                seen.read_data = read_data;
                seen.palette_valid = palette_valid;
                seen.palette_index = palette_index;
                seen.red = red;
                seen.green = green;
                seen.blue = blue;
                model.check_reply(seen);
                idle_cycles = 0;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_shifted_rop_video_memory: errors");
        $finish;
    end

    initial
    begin
        bit [2:0]  k;
        bit [13:0] a;
        bit [7:0]  d;
        int        sel;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_access(KIND_VRD, 14'h0000, 8'hff, next_gap());
        // High nibble: reversed data, shift of 1; low nibble: shift of 8.
        send_access(KIND_SHIFT, 14'h0000, 8'hf0, next_gap());
        send_access(KIND_MODE, 14'h0000, 8'(ROP_REPLACE), next_gap());
        send_access(KIND_VWR, 14'h0020, 8'ha5, next_gap());
        send_access(KIND_VRD, 14'h0020, 8'h00, next_gap());
        // Protected top rows: the write must leave memory alone.
        send_access(KIND_VWR, 14'h0005, 8'hff, next_gap());
        send_access(KIND_VRD, 14'h0005, 8'h00, next_gap());
        send_access(KIND_MODE, 14'h0000, MODE_LOW_ROWS | 8'(ROP_XOR), next_gap());
        send_access(KIND_VWR, 14'h0005, 8'hff, next_gap());
        // Right edge without roll: the second byte, at a wrapped address, is dropped.
        send_access(KIND_VWR, 14'h3f40, 8'h3c, next_gap());
        send_access(KIND_VRD, 14'h3f40, 8'h00, next_gap());
        send_access(KIND_MODE, 14'h0000, MODE_ROLL | MODE_LOW_ROWS | 8'(ROP_REPLACE_INV),
                    next_gap());
        send_access(KIND_VWR, 14'h1fe0, 8'h81, next_gap());
        send_access(KIND_VRD, 14'h1fe0, 8'h00, next_gap());
        // Shift of 8 still stamps the color of the second byte.
        send_access(KIND_SHIFT, 14'h0000, 8'h0f, next_gap());
        send_access(KIND_MODE, 14'h0000, 8'(ROP_INV_AND), next_gap());
        send_access(KIND_VWR, 14'h0060, 8'h77, next_gap());
        send_access(KIND_CRD, 14'h0160, 8'h00, next_gap());
        send_access(KIND_MODE, 14'h0000, MODE_PALETTE, next_gap());
        send_access(KIND_CWR, 14'h0000, 8'hff, next_gap());
        send_access(KIND_CWR, 14'h031f, 8'he3, next_gap());
        send_access(KIND_CWR, 14'h3fff, 8'h1f, next_gap());
        send_access(KIND_CRD, 14'h3fff, 8'h00, next_gap());
        send_access(KIND_CRD, 14'h0100, 8'h00, next_gap());
        send_access(KIND_MODE, 14'h0000, MODE_NO_COLOR | 8'(ROP_KEEP), next_gap());
        send_access(KIND_CWR, 14'h2040, 8'h55, next_gap());
        send_access(KIND_CRD, 14'h2040, 8'h00, next_gap());
        send_access(KIND_SPARE6, 14'h3fff, 8'hff, next_gap());
        send_access(KIND_SPARE7, 14'h0000, 8'h00, next_gap());

        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            sel = $urandom_range(0, 99);
            d = 8'($urandom_range(0, 255));
            a = pick_address();
            if (sel < 4)
                k = KIND_MODE;
            else if (sel < 8)
                k = KIND_SHIFT;
            else if (sel < 42)
                k = KIND_VWR;
            else if (sel < 70)
                k = KIND_VRD;
            else if (sel < 83)
                k = KIND_CWR;
            else if (sel < 95)
                k = KIND_CRD;
            else if (sel < 97)
                k = 3'($urandom_range(KIND_SPARE6, KIND_SPARE7));
            else
            begin
                k = 3'($urandom_range(0, 7));
                a = 14'($urandom_range(0, 16383));
            end
            send_access(k, a, d, next_gap());
        end
        in_valid <= 1'b0;

        while (model.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d video writes, %0d video reads, %0d color writes, %0d color reads,",
                 model.kind_count[KIND_VWR], model.kind_count[KIND_VRD],
                 model.kind_count[KIND_CWR], model.kind_count[KIND_CRD]);
        $display("%0d control writes, %0d spare-kind accesses and %0d palette updates.",
                 model.kind_count[KIND_SHIFT] + model.kind_count[KIND_MODE],
                 model.kind_count[KIND_SPARE6] + model.kind_count[KIND_SPARE7],
                 model.palette_updates);
        if (model.errors == 0 && model.pending_replies.size() == 0)
            $display("tb_shifted_rop_video_memory: clean");
        else
            $display("tb_shifted_rop_video_memory: errors");
        $finish;
    end

endmodule
